FILE: rtl/sbe_pkg.sv
package sbe_pkg;

   // Payload of one input item.
   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } req_payload_type;

   // Payload of one result item.
   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_payload_type;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [2:0] CSR_KEY_LENGTH = 3'd4;

   localparam int          ROUNDS  = 32;
   localparam int          KEY_MAX = 32;
   localparam logic [31:0] PHI     = 32'h9e3779b9;

   typedef logic [3:0][31:0] block_type;
   typedef logic [32:0][127:0] subkeys_type;

   // Four-bit S-box lookup.
   function automatic logic [3:0] sbox(input logic [2:0] box, input logic [3:0] nib);
      logic [3:0] s;
      s = 4'd0;
      case (box)
         3'd0: case (nib)
            4'd0: s=3; 4'd1: s=8; 4'd2: s=15; 4'd3: s=1; 4'd4: s=10; 4'd5: s=6;
            4'd6: s=5; 4'd7: s=11; 4'd8: s=14; 4'd9: s=13; 4'd10: s=4; 4'd11: s=2;
            4'd12: s=7; 4'd13: s=0; 4'd14: s=9; default: s=12;
         endcase
         3'd1: case (nib)
            4'd0: s=15; 4'd1: s=12; 4'd2: s=2; 4'd3: s=7; 4'd4: s=9; 4'd5: s=0;
            4'd6: s=5; 4'd7: s=10; 4'd8: s=1; 4'd9: s=11; 4'd10: s=14; 4'd11: s=8;
            4'd12: s=6; 4'd13: s=13; 4'd14: s=3; default: s=4;
         endcase
         3'd2: case (nib)
            4'd0: s=8; 4'd1: s=6; 4'd2: s=7; 4'd3: s=9; 4'd4: s=3; 4'd5: s=12;
            4'd6: s=10; 4'd7: s=15; 4'd8: s=13; 4'd9: s=1; 4'd10: s=14; 4'd11: s=4;
            4'd12: s=0; 4'd13: s=11; 4'd14: s=5; default: s=2;
         endcase
         3'd3: case (nib)
            4'd0: s=0; 4'd1: s=15; 4'd2: s=11; 4'd3: s=8; 4'd4: s=12; 4'd5: s=9;
            4'd6: s=6; 4'd7: s=3; 4'd8: s=13; 4'd9: s=1; 4'd10: s=2; 4'd11: s=4;
            4'd12: s=10; 4'd13: s=7; 4'd14: s=5; default: s=14;
         endcase
         3'd4: case (nib)
            4'd0: s=1; 4'd1: s=15; 4'd2: s=8; 4'd3: s=3; 4'd4: s=12; 4'd5: s=0;
            4'd6: s=11; 4'd7: s=6; 4'd8: s=2; 4'd9: s=5; 4'd10: s=4; 4'd11: s=10;
            4'd12: s=9; 4'd13: s=14; 4'd14: s=7; default: s=13;
         endcase
         3'd5: case (nib)
            4'd0: s=15; 4'd1: s=5; 4'd2: s=2; 4'd3: s=11; 4'd4: s=4; 4'd5: s=10;
            4'd6: s=9; 4'd7: s=12; 4'd8: s=0; 4'd9: s=3; 4'd10: s=14; 4'd11: s=8;
            4'd12: s=13; 4'd13: s=6; 4'd14: s=7; default: s=1;
         endcase
         3'd6: case (nib)
            4'd0: s=7; 4'd1: s=2; 4'd2: s=12; 4'd3: s=5; 4'd4: s=8; 4'd5: s=4;
            4'd6: s=6; 4'd7: s=11; 4'd8: s=14; 4'd9: s=9; 4'd10: s=1; 4'd11: s=15;
            4'd12: s=13; 4'd13: s=3; 4'd14: s=10; default: s=0;
         endcase
         default: case (nib)
            4'd0: s=1; 4'd1: s=13; 4'd2: s=15; 4'd3: s=0; 4'd4: s=14; 4'd5: s=8;
            4'd6: s=2; 4'd7: s=11; 4'd8: s=7; 4'd9: s=4; 4'd10: s=12; 4'd11: s=10;
            4'd12: s=9; 4'd13: s=3; 4'd14: s=5; default: s=6;
         endcase
      endcase
      return s;
   endfunction

   // Bitsliced S-box over four words.
   function automatic block_type slice_sbox(input logic [2:0] box, input block_type w);
      block_type  o;
      logic [3:0] s;
      for (int c = 0; c < 32; c++) begin
         s = sbox(box, {w[3][c], w[2][c], w[1][c], w[0][c]});
         o[0][c] = s[0];
         o[1][c] = s[1];
         o[2][c] = s[2];
         o[3][c] = s[3];
      end
      return o;
   endfunction

   function automatic logic [31:0] rol(input logic [31:0] v, input int amt);
      return (v << amt) | (v >> (32 - amt));
   endfunction

   // Linear transform between rounds.
   function automatic block_type lin_mix(input block_type wi);
      block_type w;
      w = wi;
      w[0] = rol(w[0], 13);
      w[2] = rol(w[2], 3);
      w[1] = w[1] ^ w[0] ^ w[2];
      w[3] = w[3] ^ w[2] ^ (w[0] << 3);
      w[1] = rol(w[1], 1);
      w[3] = rol(w[3], 7);
      w[0] = w[0] ^ w[1] ^ w[3];
      w[2] = w[2] ^ w[3] ^ (w[1] << 7);
      w[0] = rol(w[0], 5);
      w[2] = rol(w[2], 22);
      return w;
   endfunction

endpackage

FILE: rtl/sbe_key_schedule.sv
// Expands the configured key into the 33 round subkeys, one prekey word per
// cycle, after every key write.
module sbe_key_schedule (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [255:0]         key_bits,
   input  logic [5:0]           key_length,
   output sbe_pkg::subkeys_type subkeys
);

   logic [7:0][31:0]     win_ff, win_in;
   logic [7:0]           idx_ff, idx_in;
   logic                 busy_ff, busy_in;
   logic [127:0]         grp_ff, grp_in;
   sbe_pkg::subkeys_type sk_ff, sk_in;
   logic [255:0]         padded;
   logic [31:0]          nxt;
   logic [5:0]           len;
   logic [5:0]           k;
   logic [2:0]           box;
   sbe_pkg::block_type   sb;

   // Padding of the key to 256 bits.
   always_comb begin
      len = (key_length > 6'(sbe_pkg::KEY_MAX)) ? 6'(sbe_pkg::KEY_MAX) : key_length;
      for (int i = 0; i < 32; i++) begin
         if (6'(i) < len) begin
            padded[i*8 +: 8] = key_bits[i*8 +: 8];
         end else if (6'(i) == len) begin
            padded[i*8 +: 8] = 8'h01;
         end else begin
            padded[i*8 +: 8] = 8'h00;
         end
      end
   end

   // Prekey recurrence and S-box pass on each finished group of four.
   always_comb begin
      nxt = sbe_pkg::rol(win_ff[0] ^ win_ff[3] ^ win_ff[5] ^ win_ff[7]
                         ^ sbe_pkg::PHI ^ 32'(idx_ff), 11);
      win_in = win_ff;
      idx_in = idx_ff;
      busy_in = busy_ff;
      grp_in = grp_ff;
      sk_in = sk_ff;
      k = 6'(idx_ff >> 2);
      box = 3'(6'd35 - k);
      sb = sbe_pkg::slice_sbox(box, {nxt, grp_ff[127:32]});
      if (start) begin
         win_in = padded;
         idx_in = 8'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         win_in = {nxt, win_ff[7:1]};
         grp_in = {nxt, grp_ff[127:32]};
         if (idx_ff[1:0] == 2'd3) begin
            sk_in[k] = sb;
         end
         if (idx_ff == 8'd131) begin
            busy_in = 1'b0;
         end
         idx_in = idx_ff + 8'd1;
      end
   end

   // After reset the key is all zeros at full length, so the window starts at zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= 8'd0;
         win_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         win_ff  <= win_in;
      end
      grp_ff <= grp_in;
      sk_ff  <= sk_in;
   end

   assign subkeys = sk_ff;

endmodule

FILE: rtl/sbe_round.sv
// One cipher round as a pipeline stage with its own valid bit.
module sbe_round #(
   parameter int ROUND = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  sbe_pkg::block_type in_data,
   input  logic [127:0]       round_key,
   input  logic [127:0]       final_key,
   output logic               out_valid,
   output sbe_pkg::block_type out_data
);

   sbe_pkg::block_type data_ff, data_in, s;
   logic               valid_ff;

   // Key mix, S-box, then linear transform or final key mix.
   always_comb begin
      s = sbe_pkg::slice_sbox(3'(ROUND % 8), in_data ^ round_key);
      if (ROUND == sbe_pkg::ROUNDS - 1) begin
         data_in = s ^ final_key;
      end else begin
         data_in = sbe_pkg::lin_mix(s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/serpent_block_encrypt.sv
// Channel | Direction | Handshake        | Payload
// req_    | in        | valid / stall    | plain_low, plain_high
// rsp_    | out       | valid / stall    | cipher_low, cipher_high
// csr_    | in        | valid / ready    | index, 64-bit data
//
// There is one pipeline stage per round; one item enters per cycle while req_stall is low.
// A key write restarts the subkey expansion; csr_ready and req_stall hold during
// it, and reset starts it as well.
// A stall on a valid result freezes every stage, so nothing is lost or repeated.
module serpent_block_encrypt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sbe_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sbe_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [63:0]              csr_data
);

   logic [3:0][63:0]     key_ff;
   logic [5:0]           len_ff;
   logic [7:0]           wait_ff;
   logic                 csr_wr, advance, start;
   sbe_pkg::subkeys_type subkeys;
   logic [32:0]          v;
   sbe_pkg::block_type   d [33];

   assign csr_wr = csr_valid && csr_ready;

   // Configuration registers; each write triggers a new expansion.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         len_ff  <= 6'd32;
         wait_ff <= 8'd133;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               sbe_pkg::CSR_KEY_WORD_0: key_ff[0] <= csr_data;
               sbe_pkg::CSR_KEY_WORD_1: key_ff[1] <= csr_data;
               sbe_pkg::CSR_KEY_WORD_2: key_ff[2] <= csr_data;
               sbe_pkg::CSR_KEY_WORD_3: key_ff[3] <= csr_data;
               sbe_pkg::CSR_KEY_LENGTH: len_ff <= csr_data[5:0];
               default: ;
            endcase
         end
         if (csr_wr) begin
            wait_ff <= 8'd134;
         end else if (wait_ff != 8'd0) begin
            wait_ff <= wait_ff - 8'd1;
         end
      end
   end

   // The expansion starts the cycle after a write, from the updated registers.
   assign start     = (wait_ff == 8'd134);
   assign csr_ready = (wait_ff == 8'd0);

   sbe_key_schedule u_keys (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .key_bits   (key_ff),
      .key_length (len_ff),
      .subkeys    (subkeys)
   );

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance || (wait_ff != 8'd0);

   assign v[0] = req_valid && !req_stall;
   assign d[0] = {req_payload.plain_high, req_payload.plain_low};

   // Round pipeline.
   for (genvar r = 0; r < sbe_pkg::ROUNDS; r++) begin : g_round
      sbe_round #(.ROUND(r)) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (v[r]),
         .in_data   (d[r]),
         .round_key (subkeys[r]),
         .final_key (subkeys[32]),
         .out_valid (v[r+1]),
         .out_data  (d[r+1])
      );
   end

   assign rsp_valid   = v[32];
   assign rsp_payload = {d[32][3], d[32][2], d[32][1], d[32][0]};

endmodule

FILE: rtl/sbe_checker.sv
// Port-level checks of the encryptor.
module sbe_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input sbe_pkg::rsp_payload_type rsp_payload,
   input logic                     csr_valid,
   input logic                     csr_ready
);

   // A result that is held back stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("held result changed");

   // Items are refused while the key is being written.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("item taken during key write");

   // A stalled result side stalls the input too.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while output stalled");

   // No results straight out of reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result after reset");

endmodule

bind serpent_block_encrypt sbe_checker u_sbe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready)
);
